// ===== hw/rtl/dtti_pkg.sv =====
// Shared types, character codes and range limits for the decimal text parser.
package dtti_pkg;

  localparam int POSITION_BITS_DEF = 16;

  // configuration register indexes
  localparam logic CFG_SIGNED_MODE  = 1'b0;
  localparam logic CFG_WIDTH_SELECT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Indexed by width select: 8, 16, 32, 64 bits
  localparam logic [63:0] UMAX [4] = '{
    64'hFF, 64'hFFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
  localparam logic [63:0] SMAX [4] = '{
    64'h7F, 64'h7FFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF};
  localparam logic [63:0] SMIN [4] = '{
    64'h80, 64'h8000, 64'h8000_0000, 64'h8000_0000_0000_0000};

  localparam logic [63:0] UMAX_D10 [4] = '{
    64'hFF / 64'd10, 64'hFFFF / 64'd10, 64'hFFFF_FFFF / 64'd10,
    64'hFFFF_FFFF_FFFF_FFFF / 64'd10};
  localparam logic [63:0] SMAX_D10 [4] = '{
    64'h7F / 64'd10, 64'h7FFF / 64'd10, 64'h7FFF_FFFF / 64'd10,
    64'h7FFF_FFFF_FFFF_FFFF / 64'd10};
  localparam logic [63:0] SMIN_D10 [4] = '{
    64'h80 / 64'd10, 64'h8000 / 64'd10, 64'h8000_0000 / 64'd10,
    64'h8000_0000_0000_0000 / 64'd10};

  // Largest magnitude allowed for the selected mode, width and sign
  function automatic logic [63:0] mag_limit(input logic sgn, input logic neg,
                                            input logic [1:0] wsel);
    logic [63:0] lim;
    priority if (!sgn) lim = UMAX[wsel];
    else if (neg)      lim = SMIN[wsel];
    else               lim = SMAX[wsel];
    return lim;
  endfunction

  function automatic logic [63:0] mag_limit_d10(input logic sgn, input logic neg,
                                                input logic [1:0] wsel);
    logic [63:0] lim;
    priority if (!sgn) lim = UMAX_D10[wsel];
    else if (neg)      lim = SMIN_D10[wsel];
    else               lim = SMAX_D10[wsel];
    return lim;
  endfunction

endpackage

// ===== hw/rtl/decimal_text_to_integer.sv =====
// Streaming decimal text to integer parser, top level.
//
// Characters arrive one per word on the in_ channel, in_tlast marking the
// last character of a string. Leading whitespace is skipped, an optional
// sign is taken, then decimal digits are accumulated with an overflow check
// against the width set by width_select (8/16/32/64) and signed_mode.
// Exactly one result word per string leaves on the out_ channel: value,
// status and stop position. Characters after the result, up to and
// including the one marked last, are dropped.
// A character accepted into the input register is evaluated from there,
// and its result is written into the result register when the character
// leaves the input register.
// Throughput: one character per cycle while no result is held up on out_,
// set by the single evaluate stage (multiply by ten, add and limit compare)
// between the input register and the result register.
// When out_tready is low and a result is waiting, characters that produce
// no result still flow; a character that would produce one holds in the
// input register until the result register frees.
// Reset (rst_n low, synchronous) clears both registers, the parse state,
// and sets signed_mode to 1 and width_select to 2 (32 bits).
module decimal_text_to_integer
  import dtti_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [63:0] parsed_bits, [65:64] status,
                                  // [81:66] stop_position, [87:82] zero
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_wdata
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE} phase_t;

  logic       signed_mode_r;
  logic [1:0] width_select_r;

  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       last_r;

  phase_t                   phase_r, phase_nxt;
  logic                     neg_r, neg_nxt;
  logic [63:0]              mag_r, mag_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic        out_vld_r;
  logic [63:0] out_val_r;
  status_t     out_st_r;
  logic [15:0] out_pos_r;

  logic                     emit_c;
  logic [63:0]              res_val;
  status_t                  res_st;
  logic [POSITION_BITS-1:0] res_pos;
  logic [31:0]              res_pos_wide;
  logic                     fire;

  logic                     is_digit, is_space, is_sign;
  logic [3:0]               dig;
  logic [POSITION_BITS-1:0] pos_next;
  logic [63:0]              lim, lim_d10, new_mag;
  logic [66:0]              mag_x10;
  logic                     ovf;

  always_comb begin
    is_digit = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
    is_space = (ch_r == CH_SPACE) || ((ch_r >= CH_TAB) && (ch_r <= CH_CR));
    is_sign  = (ch_r == CH_PLUS) || ((ch_r == CH_MINUS) && signed_mode_r);
    dig      = 4'(ch_r - CH_ZERO);
    pos_next = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    lim      = mag_limit(signed_mode_r, neg_r, width_select_r);
    lim_d10  = mag_limit_d10(signed_mode_r, neg_r, width_select_r);
    mag_x10  = {mag_r, 3'b000} + {2'b00, mag_r, 1'b0};
    // first term guards the 67-bit product from wrapping
    ovf      = (mag_r > lim_d10) || (mag_x10 > {3'b000, lim - {60'd0, dig}});
    new_mag  = mag_x10[63:0] + {60'd0, dig};

    emit_c    = 1'b0;
    res_val   = '0;
    res_st    = ST_OK;
    res_pos   = '0;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    pos_nxt   = pos_next;

    unique case (phase_r)
      PH_DONE: ;
      PH_SKIP, PH_SIGN, PH_DIGITS: begin
        if (is_digit) begin
          if (ovf) begin
            emit_c    = 1'b1;
            res_st    = ST_RANGE;
            res_pos   = pos_r;
            phase_nxt = PH_DONE;
          end else begin
            mag_nxt   = new_mag;
            phase_nxt = PH_DIGITS;
            if (last_r) begin
              // digits run to the end of the string
              emit_c  = 1'b1;
              res_val = (signed_mode_r && neg_r) ? 64'd0 - new_mag : new_mag;
              res_pos = pos_next;
            end
          end
        end else if (phase_r == PH_DIGITS) begin
          emit_c    = 1'b1;
          res_pos   = pos_r;
          phase_nxt = PH_DONE;
          if (mag_r > lim) res_st = ST_RANGE;
          else res_val = (signed_mode_r && neg_r) ? 64'd0 - mag_r : mag_r;
        end else if (phase_r == PH_SKIP && (is_space || is_sign)) begin
          if (is_sign) begin
            neg_nxt   = (ch_r == CH_MINUS);
            phase_nxt = PH_SIGN;
          end
          if (last_r) begin
            emit_c = 1'b1;
            res_st = ST_INVALID;
          end
        end else begin
          emit_c    = 1'b1;
          res_st    = ST_INVALID;
          phase_nxt = PH_DONE;
        end
      end
      default: ;
    endcase

    // end of string starts the next one fresh
    if (last_r) begin
      phase_nxt = PH_SKIP;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      pos_nxt   = '0;
    end

    res_pos_wide = 32'(res_pos);
  end

  assign fire      = in_vld_r && (!emit_c || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r  <= 1'b1;
      width_select_r <= 2'd2;
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      phase_r        <= PH_SKIP;
      neg_r          <= 1'b0;
      mag_r          <= '0;
      pos_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SIGNED_MODE:  signed_mode_r  <= cfg_wdata[0];
          CFG_WIDTH_SELECT: width_select_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
        ch_r     <= in_tdata;
        last_r   <= in_tlast;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end

      if (fire) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        mag_r   <= mag_nxt;
        pos_r   <= pos_nxt;
      end

      if (fire && emit_c) begin
        out_vld_r <= 1'b1;
        out_val_r <= res_val;
        out_st_r  <= res_st;
        out_pos_r <= res_pos_wide[15:0];
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_pos_r, out_st_r, out_val_r};

endmodule

// ===== hw/rtl/dtti_checker.sv =====
// Port-level checks for the decimal text parser, bound to the top level.
module dtti_checker
  import dtti_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [1:0]  cfg_wdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[65:64] != ST_OK) |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero value on error status");

  a_invalid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[65:64] == ST_INVALID) |-> out_tdata[81:66] == 16'd0)
    else $error("nonzero position on invalid argument");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:64] == ST_OK) || (out_tdata[65:64] == ST_INVALID)
                   || (out_tdata[65:64] == ST_RANGE))
    else $error("undefined status code");

endmodule

bind decimal_text_to_integer dtti_checker u_dtti_checker (.*);

// ===== tb/sv/tb_decimal_text_to_integer.sv =====
// Self-checking testbench for the streaming decimal text to integer parser.
module tb_decimal_text_to_integer;
  import dtti_pkg::*;

  localparam logic [1:0] MODE_UNSIGNED    = 2'd0;
  localparam logic [1:0] MODE_SIGNED      = 2'd1;
  localparam logic [1:0] W8               = 2'd0;
  localparam logic [1:0] W16              = 2'd1;
  localparam logic [1:0] W32              = 2'd2;
  localparam logic [1:0] W64              = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  // digit counts reaching just past each width
  localparam int unsigned MAX_DIGITS [4] = '{4, 6, 11, 21};

  localparam logic [1:0] PHASE_MODE  [6] = '{MODE_SIGNED, MODE_UNSIGNED, MODE_SIGNED,
                                             MODE_UNSIGNED, MODE_SIGNED, MODE_UNSIGNED};
  localparam logic [1:0] PHASE_WIDTH [6] = '{W8, W8, W64, W64, W16, W32};

  localparam int unsigned DRAIN_LIMIT = 200000;

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE} scan_phase_t;

  typedef struct {
    logic [7:0]  ch;
    logic        lst;
    int unsigned gap;
  } char_word_t;

  typedef struct {
    logic [63:0] val;
    status_t     st;
    logic [15:0] pos;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;

  decimal_text_to_integer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state and register copies
  logic          cfg_signed = 1'b1;
  logic [1:0]    cfg_width = W32;
  scan_phase_t   ph = PH_SKIP;
  logic          neg_seen = 1'b0;
  logic [63:0]   acc_mag = 64'd0;
  logic [15:0]   next_pos = 16'd0;

  char_word_t    char_fifo [$];
  parse_result_t expected_parses [$];
  parse_result_t exp_r;
  char_word_t    cur_word;
  int unsigned   chars_queued = 0;
  int unsigned   chars_taken = 0;
  int unsigned   mismatches = 0;
  bit            gaps_on = 1'b1;
  bit            stall_on = 1'b1;
  bit            in_acc = 1'b0;
  bit            out_acc = 1'b0;
  bit            have_item = 1'b0;
  bit            presenting = 1'b0;
  int unsigned   wait_left = 0;
  int unsigned   stall_left = 3;

  function automatic logic [63:0] limit_for(input logic sgn, input logic [1:0] wsel,
                                            input logic neg);
    int unsigned nbits;
    logic [63:0] top;
    nbits = 8 << wsel;
    top = 64'd1 << (nbits - 1);
    if (sgn) return neg ? top : top - 64'd1;
    if (nbits == 64) return '1;
    return (64'd1 << nbits) - 64'd1;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_string();
    ph = PH_SKIP;
    neg_seen = 1'b0;
    acc_mag = 64'd0;
    next_pos = 16'd0;
  endtask

  task automatic post_result(input logic [63:0] v, input status_t st, input logic [15:0] p,
                             input logic lst);
    parse_result_t r;
    r.val = v;
    r.st = st;
    r.pos = p;
    expected_parses.push_back(r);
    if (lst) clear_string();
    else ph = PH_DONE;
  endtask

  // end of the digit run: range check against the limit in force now
  task automatic close_value(input logic [15:0] p, input logic lst);
    if (acc_mag > limit_for(cfg_signed, cfg_width, neg_seen))
      post_result(64'd0, ST_RANGE, p, lst);
    else
      post_result((cfg_signed && neg_seen) ? 64'd0 - acc_mag : acc_mag, ST_OK, p, lst);
  endtask

  task automatic parse_char(input logic [7:0] c, input logic lst);
    logic [15:0] idx;
    logic [15:0] nxt;
    logic [63:0] lim;
    logic [63:0] d;
    idx = next_pos;
    nxt = (idx != 16'hFFFF) ? idx + 16'd1 : idx;
    next_pos = nxt;
    if (ph == PH_DONE) begin
      if (lst) clear_string();
    end else if (ph == PH_SKIP && !is_digit(c)) begin
      if (is_blank(c)) begin
        if (lst) post_result(64'd0, ST_INVALID, 16'd0, 1'b1);
      end else if (c == CH_PLUS || (c == CH_MINUS && cfg_signed)) begin
        neg_seen = (c == CH_MINUS);
        ph = PH_SIGN;
        if (lst) post_result(64'd0, ST_INVALID, 16'd0, 1'b1);
      end else begin
        post_result(64'd0, ST_INVALID, 16'd0, lst);
      end
    end else if (!is_digit(c)) begin
      if (ph == PH_SIGN) post_result(64'd0, ST_INVALID, 16'd0, lst);
      else close_value(idx, lst);
    end else begin
      d = 64'(c - CH_ZERO);
      lim = limit_for(cfg_signed, cfg_width, neg_seen);
      if (acc_mag > lim / 64'd10 || acc_mag * 64'd10 > lim - d) begin
        post_result(64'd0, ST_RANGE, idx, lst);
      end else begin
        acc_mag = acc_mag * 64'd10 + d;
        ph = PH_DIGITS;
        if (lst) close_value(nxt, 1'b1);
      end
    end
  endtask

  // input side: a word is taken at the edge where valid and ready meet
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      parse_char(in_tdata, in_tlast);
      chars_taken++;
      in_acc = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (in_acc) begin
      in_acc = 1'b0;
      have_item = 1'b0;
      presenting = 1'b0;
    end
    if (!have_item && char_fifo.size() != 0) begin
      cur_word = char_fifo.pop_front();
      have_item = 1'b1;
      wait_left = cur_word.gap;
    end
    if (have_item && !presenting) begin
      if (wait_left == 0) presenting = 1'b1;
      else wait_left--;
    end
    in_tvalid <= presenting;
    in_tdata  <= cur_word.ch;
    in_tlast  <= cur_word.lst;
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      out_acc = 1'b1;
      if (expected_parses.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        mismatches++;
      end else begin
        exp_r = expected_parses.pop_front();
        if (out_tdata[63:0] !== exp_r.val) begin
          $error("parsed_bits: expected %h actual %h", exp_r.val, out_tdata[63:0]);
          mismatches++;
        end
        if (out_tdata[65:64] !== exp_r.st) begin
          $error("status: expected %0d actual %0d", exp_r.st, out_tdata[65:64]);
          mismatches++;
        end
        if (out_tdata[81:66] !== exp_r.pos) begin
          $error("stop_position: expected %0d actual %0d", exp_r.pos, out_tdata[81:66]);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (out_acc) begin
      out_acc = 1'b0;
      stall_left = stall_on ? $urandom_range(0, 15) : 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_char(input logic [7:0] c, input logic lst);
    char_word_t w;
    w.ch = c;
    w.lst = lst;
    w.gap = gaps_on ? $urandom_range(0, 15) : 0;
    char_fifo.push_back(w);
    chars_queued++;
  endtask

  task automatic queue_bytes(input logic [7:0] txt [$], input logic lst);
    int i;
    for (i = 0; i < txt.size(); i++) queue_char(txt[i], lst && i == txt.size() - 1);
  endtask

  task automatic queue_text(input string s, input logic lst);
    logic [7:0] txt [$];
    int i;
    for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_bytes(txt, lst);
  endtask

  task automatic set_reg(input logic idx, input logic [1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SIGNED_MODE) cfg_signed = val[0];
    else cfg_width = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued char is taken and every result is in,
  // then let the pipeline settle
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while ((chars_taken != chars_queued || expected_parses.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $error("stream stuck: %0d chars pending, %0d results missing",
             chars_queued - chars_taken, expected_parses.size());
      mismatches++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_random_string();
    logic [7:0]  txt [$];
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    int          i;
    logic        neg;
    logic [64:0] bnd_val;
    string       digits;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      n = $urandom_range(0, 3);
      repeat (n) txt.push_back(BLANKS[$urandom_range(0, 5)]);
      pick = $urandom_range(0, 3);
      neg = (pick == 1);
      if (pick == 0) txt.push_back(CH_PLUS);
      else if (pick == 1) txt.push_back(CH_MINUS);
      if (kind >= 6) begin
        // one below, at, or one above the limit
        bnd_val = {1'b0, limit_for(cfg_signed, cfg_width, neg)} +
                  65'($urandom_range(0, 2)) - 65'd1;
        digits = $sformatf("%0d", bnd_val);
        for (i = 0; i < digits.len(); i++) txt.push_back(digits[i]);
      end else begin
        n = $urandom_range(1, MAX_DIGITS[cfg_width]);
        repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      pick = $urandom_range(0, 3);
      if (pick == 1) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 2) begin
        n = $urandom_range(1, 3);
        repeat (n) txt.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 3) begin
        txt.push_back(BLANKS[$urandom_range(0, 5)]);
      end
    end else if (kind == 8) begin
      n = $urandom_range(1, 6);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) txt.push_back(BLANKS[$urandom_range(0, 5)]);
      end else begin
        txt.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        if (pick == 2) begin
          txt.push_back($urandom_range(0, 1) ? CH_PLUS : BLANKS[$urandom_range(0, 5)]);
          txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (pick == 3) begin
          txt.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    queue_bytes(txt, 1'b1);
  endtask

  initial begin : stimulus
    int          p;
    int          i;
    int unsigned target;
    logic [1:0]  mode;
    logic [1:0]  wsel;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: blanks only, lone sign, sign then junk, extreme bytes, ignored tail
    queue_text(" \t\r", 1'b1);
    queue_text("+", 1'b1);
    queue_text("-x", 1'b1);
    queue_char(8'hFF, 1'b1);
    queue_char(8'h00, 1'b0);
    queue_text("1", 1'b1);
    queue_text("9a4", 1'b1);
    queue_text("+-1", 1'b1);
    drain();
    set_reg(CFG_WIDTH_SELECT, W8);
    queue_text("-128", 1'b1);
    queue_text("128", 1'b1);
    drain();
    set_reg(CFG_SIGNED_MODE, MODE_UNSIGNED);
    queue_text("-1", 1'b1);
    queue_text("255", 1'b1);
    queue_text("256", 1'b1);
    drain();
    // registers switched in the middle of a string
    set_reg(CFG_SIGNED_MODE, MODE_SIGNED);
    set_reg(CFG_WIDTH_SELECT, W64);
    queue_text("-", 1'b0);
    drain();
    set_reg(CFG_SIGNED_MODE, MODE_UNSIGNED);
    queue_text("5", 1'b1);
    queue_text("200", 1'b0);
    drain();
    set_reg(CFG_SIGNED_MODE, MODE_SIGNED);
    set_reg(CFG_WIDTH_SELECT, W8);
    queue_text("x", 1'b1);
    drain();

    // back-to-back run of blanks ahead of a digit
    set_reg(CFG_WIDTH_SELECT, W32);
    gaps_on = 1'b0;
    for (i = 0; i < 12; i++) queue_char(CH_SPACE, 1'b0);
    queue_text("7x", 1'b1);

    for (p = 0; p < 8; p++) begin
      drain();
      gaps_on = (p != 2);
      stall_on = (p != 3);
      mode = (p < 6) ? PHASE_MODE[p] : 2'($urandom_range(0, 1));
      wsel = (p < 6) ? PHASE_WIDTH[p] : 2'($urandom_range(0, 3));
      set_reg(CFG_SIGNED_MODE, mode);
      set_reg(CFG_WIDTH_SELECT, wsel);
      target = chars_queued + 62;
      while (chars_queued < target) queue_random_string();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
